// ----- rtl/smde_pkg.sv -----
`default_nettype none

package smde_pkg;

	localparam int DEF_MATRIX_HEIGHT = 8;
	localparam int DEF_MATRIX_WIDTH  = 8;
	localparam int MAX_RESULTS       = 64;
	localparam int COUNT_W           = $clog2(MAX_RESULTS);
	localparam int CMD_W             = 3;
	localparam int COORD_W           = 6;
	localparam int LEN_W             = 6;
	localparam int COLOR_W           = 8;
	localparam int KIND_W            = 2;
	localparam int ADDR_W            = 6;
	localparam int WIDE_W            = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_OPEN  = 3'd0,
		CMD_POINT = 3'd1,
		CMD_HLINE = 3'd2,
		CMD_VLINE = 3'd3,
		CMD_RECT  = 3'd4,
		CMD_CLOSE = 3'd5
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PIXEL = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_SHOW  = 2'd2
	} kind_t;

	typedef struct packed {
		logic  load_in;
		logic  clip;
		logic  start_walk;
		logic  emit_pixel;
		logic  emit_mark;
		kind_t mark_kind;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             nonempty;
		logic             pix_last;
		logic             out_free;
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/smde_ctrl.sv -----
`default_nettype none

module smde_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  smde_pkg::status_t     status,
	output smde_pkg::ctrl_cmd_t   ctrl
);
	import smde_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_CLIP     = 5'b00010,
		ST_DISPATCH = 5'b00100,
		ST_MARK     = 5'b01000,
		ST_WALK     = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   open_q, open_d;
	kind_t  mark_kind_q, mark_kind_d;

	always_comb begin
		state_d         = state_q;
		open_d          = open_q;
		mark_kind_d     = mark_kind_q;
		ctrl            = '0;
		ctrl.mark_kind  = mark_kind_q;
		in_stall        = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctrl.load_in = 1'b1;
					state_d      = ST_CLIP;
				end
			end
			ST_CLIP: begin
				ctrl.clip = 1'b1;
				state_d   = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				state_d = ST_IDLE;
				unique case (status.cmd) inside
					CMD_OPEN: begin
						if (!open_q) begin
							open_d      = 1'b1;
							mark_kind_d = KIND_CLEAR;
							state_d     = ST_MARK;
						end
					end
					CMD_CLOSE: begin
						if (open_q) begin
							open_d      = 1'b0;
							mark_kind_d = KIND_SHOW;
							state_d     = ST_MARK;
						end
					end
					CMD_POINT, CMD_HLINE, CMD_VLINE, CMD_RECT: begin
						if (open_q && status.nonempty) begin
							ctrl.start_walk = 1'b1;
							state_d         = ST_WALK;
						end
					end
					default: begin
					end
				endcase
			end
			ST_MARK: begin
				if (status.out_free) begin
					ctrl.emit_mark = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_WALK: begin
				if (status.out_free) begin
					ctrl.emit_pixel = 1'b1;
					if (status.pix_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			open_q      <= 1'b0;
			mark_kind_q <= KIND_CLEAR;
		end else begin
			state_q     <= state_d;
			open_q      <= open_d;
			mark_kind_q <= mark_kind_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/smde_datapath.sv -----
`default_nettype none

module smde_datapath #(
	parameter int MATRIX_HEIGHT = smde_pkg::DEF_MATRIX_HEIGHT,
	parameter int MATRIX_WIDTH  = smde_pkg::DEF_MATRIX_WIDTH
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  smde_pkg::ctrl_cmd_t                   ctrl,
	output smde_pkg::status_t                     status,
	input  wire        [smde_pkg::CMD_W-1:0]      cmd,
	input  wire signed [smde_pkg::COORD_W-1:0]    start_x,
	input  wire signed [smde_pkg::COORD_W-1:0]    start_y,
	input  wire        [smde_pkg::LEN_W-1:0]      length,
	input  wire signed [smde_pkg::COORD_W-1:0]    end_x,
	input  wire signed [smde_pkg::COORD_W-1:0]    end_y,
	input  wire        [smde_pkg::COLOR_W-1:0]    red,
	input  wire        [smde_pkg::COLOR_W-1:0]    green,
	input  wire        [smde_pkg::COLOR_W-1:0]    blue,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic       [smde_pkg::KIND_W-1:0]     kind,
	output logic       [smde_pkg::ADDR_W-1:0]     address,
	output logic       [smde_pkg::COLOR_W-1:0]    out_red,
	output logic       [smde_pkg::COLOR_W-1:0]    out_green,
	output logic       [smde_pkg::COLOR_W-1:0]    out_blue,
	output logic                                  last
);
	import smde_pkg::*;

	localparam int CW      = (MATRIX_WIDTH > 1) ? $clog2(MATRIX_WIDTH) : 1;
	localparam int RW      = $clog2(MATRIX_HEIGHT);
	localparam int LIN_RAW = $clog2(MATRIX_WIDTH * MATRIX_HEIGHT);
	localparam int LIN_W   = (LIN_RAW > ADDR_W) ? LIN_RAW : ADDR_W;
	localparam logic signed [WIDE_W-1:0] XMAX = WIDE_W'(MATRIX_WIDTH - 1);
	localparam logic signed [WIDE_W-1:0] YMAX = WIDE_W'(MATRIX_HEIGHT - 1);
	localparam logic signed [WIDE_W-1:0] ZERO = '0;
	localparam logic signed [WIDE_W-1:0] ONE  = WIDE_W'(1);

	logic        [CMD_W-1:0]   cmd_q;
	logic signed [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;
	logic        [LEN_W-1:0]   len_q;
	logic        [COLOR_W-1:0] red_q, green_q, blue_q;

	logic signed [WIDE_W-1:0] sx8, sy8, ex8, ey8, len8;
	logic signed [WIDE_W-1:0] xl, xh, yl, yh;
	logic signed [WIDE_W-1:0] x0_q, x1_q, y0_q, y1_q;

	logic [CW-1:0]      x_q;
	logic [RW-1:0]      y_q;
	logic [COUNT_W-1:0] count_q;
	logic               at_row_end, at_end;
	logic [LIN_W-1:0]   lin;

	logic                  valid_q, last_q;
	logic [KIND_W-1:0]     kind_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [COLOR_W-1:0]    ored_q, ogreen_q, oblue_q;

	always_ff @(posedge clk) begin
		if (ctrl.load_in) begin
			cmd_q   <= cmd;
			sx_q    <= start_x;
			sy_q    <= start_y;
			len_q   <= length;
			ex_q    <= end_x;
			ey_q    <= end_y;
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
		end
	end

	assign sx8  = WIDE_W'(sx_q);
	assign sy8  = WIDE_W'(sy_q);
	assign ex8  = WIDE_W'(ex_q);
	assign ey8  = WIDE_W'(ey_q);
	assign len8 = signed'({{(WIDE_W-LEN_W){1'b0}}, len_q});

	always_comb begin
		xl = sx8;
		xh = sx8;
		yl = sy8;
		yh = sy8;
		case (cmd_q)
			CMD_HLINE: xh = sx8 + len8 - ONE;
			CMD_VLINE: yh = sy8 + len8 - ONE;
			CMD_RECT: begin
				xh = ex8;
				yh = ey8;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.clip) begin
			x0_q <= (xl < ZERO) ? ZERO : xl;
			x1_q <= (xh > XMAX) ? XMAX : xh;
			y0_q <= (yl < ZERO) ? ZERO : yl;
			y1_q <= (yh > YMAX) ? YMAX : yh;
		end
	end

	assign at_row_end = (x_q == x1_q[CW-1:0]);
	assign at_end     = at_row_end && (y_q == y1_q[RW-1:0]);

	always_ff @(posedge clk) begin
		if (ctrl.start_walk) begin
			x_q     <= x0_q[CW-1:0];
			y_q     <= y0_q[RW-1:0];
			count_q <= '0;
		end else if (ctrl.emit_pixel) begin
			count_q <= count_q + COUNT_W'(1);
			if (at_row_end) begin
				x_q <= x0_q[CW-1:0];
				y_q <= y_q + RW'(1);
			end else begin
				x_q <= x_q + CW'(1);
			end
		end
	end

	assign lin = LIN_W'(MATRIX_HEIGHT) * LIN_W'(x_q)
		+ (x_q[0] ? LIN_W'(y_q) : (LIN_W'(MATRIX_HEIGHT - 1) - LIN_W'(y_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.emit_pixel || ctrl.emit_mark) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit_pixel) begin
			kind_q   <= KIND_PIXEL;
			addr_q   <= lin[ADDR_W-1:0];
			ored_q   <= red_q;
			ogreen_q <= green_q;
			oblue_q  <= blue_q;
			last_q   <= at_end || (count_q == COUNT_W'(MAX_RESULTS - 1));
		end else if (ctrl.emit_mark) begin
			kind_q   <= ctrl.mark_kind;
			addr_q   <= '0;
			ored_q   <= '0;
			ogreen_q <= '0;
			oblue_q  <= '0;
			last_q   <= 1'b1;
		end
	end

	assign status.cmd      = cmd_q;
	assign status.nonempty = (x0_q <= x1_q) && (y0_q <= y1_q);
	assign status.pix_last = at_end || (count_q == COUNT_W'(MAX_RESULTS - 1));
	assign status.out_free = !valid_q || !out_stall;

	assign out_valid = valid_q;
	assign kind      = kind_q;
	assign address   = addr_q;
	assign out_red   = ored_q;
	assign out_green = ogreen_q;
	assign out_blue  = oblue_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ----- rtl/serpentine_matrix_draw_engine.sv -----
// Channel   Direction  Handshake              Payload
// command   in         in_valid / in_stall    cmd, start_x, start_y, length, end_x, end_y,
//                                             red, green, blue
// result    out        out_valid / out_stall  kind, address, out_red, out_green, out_blue, last
//
// A command is registered, clipped and dispatched, then the results it causes are issued in turn.
// The pixel walk issues one write per cycle from its column and row counters unless out_stall holds it.
// Reset is asynchronous and active low; it closes the display and empties the output register.
// While out_stall is high the output register holds its transaction and the walk waits.
`default_nettype none

module serpentine_matrix_draw_engine #(
	parameter int MATRIX_HEIGHT = smde_pkg::DEF_MATRIX_HEIGHT,
	parameter int MATRIX_WIDTH  = smde_pkg::DEF_MATRIX_WIDTH
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire        [smde_pkg::CMD_W-1:0]      cmd,
	input  wire signed [smde_pkg::COORD_W-1:0]    start_x,
	input  wire signed [smde_pkg::COORD_W-1:0]    start_y,
	input  wire        [smde_pkg::LEN_W-1:0]      length,
	input  wire signed [smde_pkg::COORD_W-1:0]    end_x,
	input  wire signed [smde_pkg::COORD_W-1:0]    end_y,
	input  wire        [smde_pkg::COLOR_W-1:0]    red,
	input  wire        [smde_pkg::COLOR_W-1:0]    green,
	input  wire        [smde_pkg::COLOR_W-1:0]    blue,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic       [smde_pkg::KIND_W-1:0]     kind,
	output logic       [smde_pkg::ADDR_W-1:0]     address,
	output logic       [smde_pkg::COLOR_W-1:0]    out_red,
	output logic       [smde_pkg::COLOR_W-1:0]    out_green,
	output logic       [smde_pkg::COLOR_W-1:0]    out_blue,
	output logic                                  last
);
	import smde_pkg::*;

	ctrl_cmd_t ctrl;
	status_t   status;

	smde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.ctrl     (ctrl)
	);

	smde_datapath #(
		.MATRIX_HEIGHT (MATRIX_HEIGHT),
		.MATRIX_WIDTH  (MATRIX_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.status    (status),
		.cmd       (cmd),
		.start_x   (start_x),
		.start_y   (start_y),
		.length    (length),
		.end_x     (end_x),
		.end_y     (end_y),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.address   (address),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.last      (last)
	);

endmodule

`default_nettype wire

// ----- rtl/smde_checker.sv -----
`default_nettype none

module smde_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               in_valid,
	input wire                               in_stall,
	input wire                               out_valid,
	input wire                               out_stall,
	input wire [smde_pkg::KIND_W-1:0]        kind,
	input wire [smde_pkg::ADDR_W-1:0]        address,
	input wire [smde_pkg::COLOR_W-1:0]       out_red,
	input wire [smde_pkg::COLOR_W-1:0]       out_green,
	input wire [smde_pkg::COLOR_W-1:0]       out_blue,
	input wire                               last
);
	import smde_pkg::*;

	// A held result transaction stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction withdrawn while stalled");

	// Markers always close their command.
	a_mark_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_PIXEL) |-> last)
		else $error("marker without last");

	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_PIXEL) |->
		(address == '0) && (out_red == '0) && (out_green == '0) && (out_blue == '0))
		else $error("marker carries address or colour");

	// An accepted command keeps the block busy for the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("command accepted twice in consecutive cycles");

endmodule

bind serpentine_matrix_draw_engine smde_checker u_smde_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.kind      (kind),
	.address   (address),
	.out_red   (out_red),
	.out_green (out_green),
	.out_blue  (out_blue),
	.last      (last)
);

`default_nettype wire
